FILE: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg: shared constants for the triangle unit normal block
// Default widths of the corner coordinates and of the result fraction, and the axis count.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int NUM_AXES         = 3;

endpackage

FILE: sv/triangle_unit_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_top: unit face normal of a triangle
// Cross product of the edges from the first corner, exact normalization, round to nearest.
// ----------------------------------------------------------------------------
// One triangle enters per clock cycle while s_axis_tready is high. Eight stages
// form the edges, the cross product, its squares split into half-width partial
// products and the squared length, then one stage per result bit settles all
// three components at once, and a last stage registers the result. Each stage
// holds when the next one is full and stalled, so bubbles close up and ready
// drops only when the whole pipeline is full. A zero cross product returns
// (0, 0, 1.0) with tuser set.
module triangle_unit_normal_top #(
  parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z from bit 0 up, zero fill to bytes
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // normal_x, normal_y, normal_z from bit 0 up, zero fill to bytes
  output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic m_axis_tuser
);
  import tun_pkg::*;

  localparam int F    = NORMAL_FRAC_BITS;
  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * CW + 1;
  localparam int NW   = 2 * CW + 2;
  localparam int MW   = NW - 1;
  localparam int LO   = (MW + 1) / 2;
  localparam int HI   = MW - LO;
  localparam int SQW  = 2 * MW;
  localparam int SW   = SQW + 2;
  localparam int W    = SW + 2 * F + 5;
  localparam int RW   = F + 1;
  localparam int OW   = F + 2;
  localparam int TDW  = ((3 * OW + 7) / 8) * 8;
  localparam int DIG0 = 9;
  localparam int NST  = F + 10;

  logic [NST:1]   v;
  logic [NST+1:1] en;

  always_comb begin
    en[NST+1] = m_axis_tready;
    for (int i = NST; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_axis_tvalid;
      for (int i = 2; i <= NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Stage 1: edges from the first corner
  logic signed [CW-1:0] crd [9];
  logic signed [DW-1:0] u [NUM_AXES];
  logic signed [DW-1:0] w [NUM_AXES];

  always_comb begin
    for (int i = 0; i < 9; i++) crd[i] = s_axis_tdata[i*CW +: CW];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        u[a] <= DW'(crd[3+a]) - DW'(crd[a]);
        w[a] <= DW'(crd[6+a]) - DW'(crd[a]);
      end
    end
  end

  // Stage 2: products of edge components for the cross product
  logic signed [PW-1:0] pm [6];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pm[0] <= PW'(u[1]) * PW'(w[2]);
      pm[1] <= PW'(u[2]) * PW'(w[1]);
      pm[2] <= PW'(u[2]) * PW'(w[0]);
      pm[3] <= PW'(u[0]) * PW'(w[2]);
      pm[4] <= PW'(u[0]) * PW'(w[1]);
      pm[5] <= PW'(u[1]) * PW'(w[0]);
    end
  end

  // Stage 3: cross product
  logic signed [NW-1:0] n [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        n[a] <= NW'(pm[2*a]) - NW'(pm[2*a+1]);
      end
    end
  end

  // Stage 4: magnitude and sign
  logic [MW-1:0] mag [NUM_AXES];
  logic [NUM_AXES-1:0] neg4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        neg4[a] <= n[a][NW-1];
        mag[a]  <= n[a][NW-1] ? MW'(-n[a]) : MW'(n[a]);
      end
    end
  end

  // Stage 5: half-width partial products of each square
  logic [2*HI-1:0]    hh [NUM_AXES];
  logic [HI+LO-1:0]   hl [NUM_AXES];
  logic [2*LO-1:0]    ll [NUM_AXES];
  logic [NUM_AXES-1:0] neg5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      neg5 <= neg4;
      for (int a = 0; a < NUM_AXES; a++) begin
        hh[a] <= (2*HI)'(mag[a][MW-1:LO]) * (2*HI)'(mag[a][MW-1:LO]);
        hl[a] <= (HI+LO)'(mag[a][MW-1:LO]) * (HI+LO)'(mag[a][LO-1:0]);
        ll[a] <= (2*LO)'(mag[a][LO-1:0]) * (2*LO)'(mag[a][LO-1:0]);
      end
    end
  end

  // Stage 6: squares
  logic [SQW-1:0] sq6 [NUM_AXES];
  logic [NUM_AXES-1:0] neg6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      neg6 <= neg5;
      for (int a = 0; a < NUM_AXES; a++) begin
        sq6[a] <= (SQW'(hh[a]) << (2 * LO)) + (SQW'(hl[a]) << (LO + 1)) + SQW'(ll[a]);
      end
    end
  end

  // Stage 7: squared length
  logic [SQW-1:0] sq7 [NUM_AXES];
  logic [SW-1:0]  s7;
  logic [NUM_AXES-1:0] neg7;
  logic deg7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      neg7 <= neg6;
      sq7  <= sq6;
      s7   <= SW'(sq6[0]) + SW'(sq6[1]) + SW'(sq6[2]);
      deg7 <= (sq6[0] | sq6[1] | sq6[2]) == '0;
    end
  end

  // Stage 8 and the bit stages
  logic signed [W-1:0]  e_st [NUM_AXES][F+2];
  logic signed [W-1:0]  p_st [NUM_AXES][F+2];
  logic        [RW-1:0] r_st [NUM_AXES][F+2];
  logic        [SW-1:0] s_st [F+2];
  logic [NUM_AXES-1:0]  neg_st [F+2];
  logic                 deg_st [F+2];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s_st[0]   <= s7;
      neg_st[0] <= neg7;
      deg_st[0] <= deg7;
      for (int a = 0; a < NUM_AXES; a++) begin
        e_st[a][0] <= (W'(sq7[a]) <<< (2 * F + 2)) - W'(s7);
        p_st[a][0] <= -W'(s7);
        r_st[a][0] <= '0;
      end
    end
  end

  for (genvar j = 0; j <= F; j++) begin : g_bit
    always_ff @(posedge clk) begin
      if (en[DIG0+j]) begin
        s_st[j+1]   <= s_st[j];
        neg_st[j+1] <= neg_st[j];
        deg_st[j+1] <= deg_st[j];
      end
    end
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      tun_digit #(
        .W  (W),
        .SW (SW),
        .RW (RW),
        .K  (F - j)
      ) u_digit (
        .clk   (clk),
        .en    (en[DIG0+j]),
        .e_in  (e_st[a][j]),
        .p_in  (p_st[a][j]),
        .s_in  (s_st[j]),
        .r_in  (r_st[a][j]),
        .e_out (e_st[a][j+1]),
        .p_out (p_st[a][j+1]),
        .r_out (r_st[a][j+1])
      );
    end
  end

  // Output stage
  logic [OW-1:0] nrm [NUM_AXES];
  logic          deg_out;

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      deg_out <= deg_st[F+1];
      for (int a = 0; a < NUM_AXES; a++) begin
        if (deg_st[F+1]) begin
          nrm[a] <= (a == NUM_AXES - 1) ? OW'(RW'(1) << F) : '0;
        end else if (neg_st[F+1][a]) begin
          nrm[a] <= OW'(0) - OW'(r_st[a][F+1]);
        end else begin
          nrm[a] <= OW'(r_st[a][F+1]);
        end
      end
    end
  end

  assign m_axis_tvalid = v[NST];
  assign m_axis_tdata  = TDW'({nrm[2], nrm[1], nrm[0]});
  assign m_axis_tuser  = deg_out;

  // A unit component never exceeds 1.0; a zero length sets every bit, so skip it
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (v[NST-1] && !deg_st[F+1]) |-> (r_st[0][F+1] <= RW'(1) << F)
                 && (r_st[1][F+1] <= RW'(1) << F) && (r_st[2][F+1] <= RW'(1) << F))
    else $error("unit component above one");

  // A nonzero cross product leaves at least one component nonzero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (v[NST-1] && !deg_st[F+1]) |-> ((r_st[0][F+1] | r_st[1][F+1] | r_st[2][F+1]) != '0))
    else $error("nondegenerate triangle gave zero normal");

  // An item accepted at the input is valid in the first stage on the next cycle
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v[1])
    else $error("accepted item lost at first stage");

endmodule

FILE: sv/tun_digit.sv
// ----------------------------------------------------------------------------
// tun_digit: one bit of the rounded unit component
// Tries to set bit K of the result by one restoring step on the tracked error.
// ----------------------------------------------------------------------------
module tun_digit #(
  parameter int W  = 135,
  parameter int SW = 102,
  parameter int RW = 15,
  parameter int K  = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  e_in,
  input  logic signed [W-1:0]  p_in,
  input  logic        [SW-1:0] s_in,
  input  logic        [RW-1:0] r_in,
  output logic signed [W-1:0]  e_out,
  output logic signed [W-1:0]  p_out,
  output logic        [RW-1:0] r_out
);

  logic signed [W-1:0] s_ext;
  logic signed [W-1:0] p_term;
  logic signed [W-1:0] s_term;
  logic signed [W-1:0] trial;
  logic                take;

  // E tracks 4*n^2*2^(2F) - (2r-1)^2*s, P tracks (2r-1)*s
  assign s_ext  = W'(s_in);
  assign p_term = p_in <<< (K + 2);
  assign s_term = s_ext <<< (2 * K + 2);
  assign trial  = e_in - (p_term + s_term);
  assign take   = !trial[W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        e_out <= trial;
        p_out <= p_in + (s_ext <<< (K + 1));
        r_out <= r_in | (RW'(1) << K);
      end else begin
        e_out <= e_in;
        p_out <= p_in;
        r_out <= r_in;
      end
    end
  end

endmodule

FILE: tb/tun_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_checker: result checker for the triangle unit normal block
// Watches both stream channels, works out the normal of every accepted
// triangle with exact integer arithmetic and compares it with the results.
// ----------------------------------------------------------------------------
module tun_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [215:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           errors,
  output int           pending
);

  localparam int FRAC = tun_pkg::NORMAL_FRAC_BITS;
  localparam int CW   = tun_pkg::COORD_WIDTH;

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degenerate;
  } normal_t;

  normal_t normal_q[$];

  // round(n * 2^F / sqrt(s)) by bisection on (2m-1)^2 * s <= 4 * n^2 * 2^2F
  function automatic logic [15:0] scale_component(longint n, logic [159:0] s);
    logic [159:0] mag;
    logic [159:0] rhs;
    logic [159:0] dd;
    logic [159:0] lhs;
    longint lo;
    longint hi;
    longint mid;
    mag = (n < 0) ? -n : n;
    rhs = (mag * mag) << (2 * FRAC + 2);
    lo = 0;
    hi = longint'(1) << FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      dd = 2 * mid - 1;
      lhs = dd * dd * s;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (n < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic normal_t face_normal(logic [215:0] d);
    longint c[9];
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [159:0] s;
    normal_t r;
    for (int i = 0; i < 9; i++) c[i] = longint'($signed(d[i*CW +: CW]));
    ux = c[3] - c[0]; uy = c[4] - c[1]; uz = c[5] - c[2];
    vx = c[6] - c[0]; vy = c[7] - c[1]; vz = c[8] - c[2];
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    if (nx == 0 && ny == 0 && nz == 0) begin
      r.nx = '0;
      r.ny = '0;
      r.nz = 16'(1 << FRAC);
      r.degenerate = 1'b1;
    end else begin
      s = 160'($signed(nx)) * 160'($signed(nx)) + 160'($signed(ny)) * 160'($signed(ny))
        + 160'($signed(nz)) * 160'($signed(nz));
      r.nx = scale_component(nx, s);
      r.ny = scale_component(ny, s);
      r.nz = scale_component(nz, s);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  initial errors = 0;
  assign pending = normal_q.size();

  always @(posedge clk) begin
    normal_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) normal_q = {normal_q, face_normal(s_axis_tdata)};
      if (m_axis_tvalid && m_axis_tready) begin
        if (normal_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: %h %b", $time, m_axis_tdata,
                   m_axis_tuser);
        end else begin
          want = normal_q.pop_front();
          if (m_axis_tdata[15:0] !== want.nx) begin
            errors++;
            $display("%0t: normal_x expected %h actual %h", $time, want.nx,
                     m_axis_tdata[15:0]);
          end
          if (m_axis_tdata[31:16] !== want.ny) begin
            errors++;
            $display("%0t: normal_y expected %h actual %h", $time, want.ny,
                     m_axis_tdata[31:16]);
          end
          if (m_axis_tdata[47:32] !== want.nz) begin
            errors++;
            $display("%0t: normal_z expected %h actual %h", $time, want.nz,
                     m_axis_tdata[47:32]);
          end
          if (m_axis_tuser !== want.degenerate) begin
            errors++;
            $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                     m_axis_tuser);
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus for the triangle unit normal block
// Directed extreme and degenerate triangles, then random triangles of mixed
// shape, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int CW = tun_pkg::COORD_WIDTH;
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;
  int           errors;
  int           pending;

  triangle_unit_normal_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  tun_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [215:0] corners(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz);
    int v[9];
    logic [215:0] d;
    v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    for (int i = 0; i < 9; i++) d[i*CW +: CW] = v[i][CW-1:0];
    return d;
  endfunction

  function automatic int any_coord();
    return int'($signed(CW'($urandom)));
  endfunction

  task automatic send_triangle(input logic [215:0] d);
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    r = $urandom_range(0, 19);
    if (r >= 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ((r < 19) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    end
  endtask

  // receiver: short random stalls, one long hold-off early in the random part
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(negedge rst);
    repeat (120) @(posedge clk) m_axis_tready <= 1'b1;
    hold = 400;
    while (hold > 0) begin
      @(posedge clk) m_axis_tready <= 1'b0;
      hold--;
    end
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk) m_axis_tready <= 1'b1;
      hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      repeat (hold) @(posedge clk) m_axis_tready <= 1'b0;
    end
  end

  initial begin
    int ax, ay, az, dx, dy, dz, k1, k2, sel;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all corners equal, at zero and at the extremes
    send_triangle(corners(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(corners(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_triangle(corners(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    // collinear corners
    send_triangle(corners(1, 2, 3, 2, 4, 6, 3, 6, 9));
    send_triangle(corners(CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX));
    // axis-aligned faces give exact unit components of both signs
    send_triangle(corners(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    send_triangle(corners(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
    send_triangle(corners(0, 0, 0, 0, 4096, 0, 0, 0, 4096));
    send_triangle(corners(0, 0, 0, 0, 0, 4096, 0, 4096, 0));
    send_triangle(corners(0, 0, 0, 0, 0, 4096, 4096, 0, 0));
    send_triangle(corners(0, 0, 0, 4096, 0, 0, 0, 0, 4096));
    // largest edges and cross products
    send_triangle(corners(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
    send_triangle(corners(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
    send_triangle(corners(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
    send_triangle(corners(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN));
    // smallest nonzero cross product, diagonal normals
    send_triangle(corners(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(corners(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_triangle(corners(0, 0, 1, 0, 1, 0, 1, 0, 0));
    send_triangle(corners(-1, -1, -1, 1, 0, 0, 0, 1, 0));

    for (int n = 0; n < 1300; n++) begin
      sel = $urandom_range(0, 9);
      ax = any_coord(); ay = any_coord(); az = any_coord();
      if (sel <= 3) begin
        send_triangle(corners(ax, ay, az, any_coord(), any_coord(), any_coord(),
                              any_coord(), any_coord(), any_coord()));
      end else if (sel <= 6) begin
        // small triangle somewhere in space
        send_triangle(corners(ax, ay, az,
          ax + $signed($urandom_range(0, 8192)) - 4096,
          ay + $signed($urandom_range(0, 8192)) - 4096,
          az + $signed($urandom_range(0, 8192)) - 4096,
          ax + $signed($urandom_range(0, 8192)) - 4096,
          ay + $signed($urandom_range(0, 8192)) - 4096,
          az + $signed($urandom_range(0, 8192)) - 4096));
      end else if (sel == 7) begin
        // two corners coincide
        dx = any_coord(); dy = any_coord(); dz = any_coord();
        case ($urandom_range(0, 2))
          0: send_triangle(corners(ax, ay, az, ax, ay, az, dx, dy, dz));
          1: send_triangle(corners(ax, ay, az, dx, dy, dz, ax, ay, az));
          default: send_triangle(corners(ax, ay, az, dx, dy, dz, dx, dy, dz));
        endcase
      end else if (sel == 8) begin
        // collinear corners
        ax = ax >>> 2; ay = ay >>> 2; az = az >>> 2;
        dx = $signed($urandom_range(0, 2000)) - 1000;
        dy = $signed($urandom_range(0, 2000)) - 1000;
        dz = $signed($urandom_range(0, 2000)) - 1000;
        k1 = $signed($urandom_range(0, 200)) - 100;
        k2 = $signed($urandom_range(0, 200)) - 100;
        send_triangle(corners(ax, ay, az, ax + k1 * dx, ay + k1 * dy, az + k1 * dz,
                              ax + k2 * dx, ay + k2 * dy, az + k2 * dz));
      end else begin
        // face parallel to the xy plane
        dx = any_coord(); dy = any_coord();
        send_triangle(corners(ax, ay, az, dx, dy, az, any_coord(), any_coord(), az));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
